// ===== rtl/core/u8dec_pkg.sv =====
// Shared types and constants for the UTF-8 stream decoder.
// No dependencies; imported by every module of the block.
`default_nettype none

package u8dec_pkg;

    localparam int FIELD_W    = 24;
    localparam int CODE_W     = 31;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [FIELD_W-1:0] BUF_CHARS_RESET = 24'd1024;

    // register index (paddr[2])
    localparam logic REG_BUFFER_CHARS = 1'b0;

    typedef logic [1:0] t_kind;

    localparam t_kind KIND_CHAR      = 2'd0;
    localparam t_kind KIND_END_OK    = 2'd1;
    localparam t_kind KIND_END_TRUNC = 2'd2;
    localparam t_kind KIND_BAD_LEAD  = 2'd3;

    typedef struct packed {
        t_kind               kind;
        logic [CODE_W-1:0]   code_point;
        logic [FIELD_W-1:0]  index_or_total;
        logic                stored;
    } t_result;

endpackage

`default_nettype wire

// ===== rtl/core/u8dec_cfg.sv =====
// APB-style configuration register file: holds buffer_chars.
// Depends on u8dec_pkg.
`default_nettype none

module u8dec_cfg
    import u8dec_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [CFG_DATA_W-1:0] pwdata,
    output logic      [CFG_DATA_W-1:0] prdata,
    output logic                       pready,
    output logic      [FIELD_W-1:0]    o_buffer_chars
);

    logic [FIELD_W-1:0] r_buffer_chars;
    logic [FIELD_W-1:0] n_buffer_chars;
    logic               wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite & (paddr[2] == REG_BUFFER_CHARS);

    always_comb begin
        n_buffer_chars = r_buffer_chars;
        if (wr_en) begin
            n_buffer_chars = pwdata[FIELD_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buffer_chars <= BUF_CHARS_RESET;
        end else begin
            r_buffer_chars <= n_buffer_chars;
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == REG_BUFFER_CHARS) begin
            prdata = {{(CFG_DATA_W-FIELD_W){1'b0}}, r_buffer_chars};
        end
    end

    assign o_buffer_chars = r_buffer_chars;

endmodule

`default_nettype wire

// ===== rtl/core/u8dec_core.sv =====
// Decode state (bytes due, partial code point, character count) and the
// per-byte datapath producing at most one result. Depends on u8dec_pkg.
`default_nettype none

module u8dec_core
    import u8dec_pkg::*;
#(
    parameter int COUNT_BITS = 24
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_accept,
    input  wire logic [7:0]         i_data_byte,
    input  wire logic [FIELD_W-1:0] i_buffer_chars,
    output logic                    o_res_valid,
    output t_result                 o_res
);

    localparam int CMP_W = (COUNT_BITS > FIELD_W) ? COUNT_BITS : FIELD_W;
    localparam int TOT_W = COUNT_BITS + 1;

    logic [2:0]            r_bytes_left, n_bytes_left;
    logic [CODE_W-1:0]     r_partial, n_partial;
    logic [COUNT_BITS-1:0] r_char_count, n_char_count;

    logic [CODE_W-1:0]     shifted;
    logic [COUNT_BITS-1:0] count_inc;
    logic [TOT_W-1:0]      total_wide;
    logic [FIELD_W-1:0]    index_sat;
    logic [FIELD_W-1:0]    total_sat;
    logic [CMP_W-1:0]      count_ext;
    logic [CMP_W-1:0]      buf_ext;
    logic                  below_buf;

    assign shifted    = {r_partial[CODE_W-7:0], i_data_byte[5:0]};
    assign count_inc  = (&r_char_count) ? r_char_count : r_char_count + 1'b1;
    assign total_wide = {1'b0, r_char_count} + 1'b1;
    assign count_ext  = CMP_W'(r_char_count);
    assign buf_ext    = CMP_W'(i_buffer_chars);
    assign below_buf  = count_ext < buf_ext;

    generate
        if (COUNT_BITS > FIELD_W) begin : g_idx_clamp
            assign index_sat = (|r_char_count[COUNT_BITS-1:FIELD_W]) ?
                               {FIELD_W{1'b1}} : r_char_count[FIELD_W-1:0];
        end else begin : g_idx_ext
            assign index_sat = FIELD_W'(r_char_count);
        end
        if (TOT_W > FIELD_W) begin : g_tot_clamp
            assign total_sat = (|total_wide[TOT_W-1:FIELD_W]) ?
                               {FIELD_W{1'b1}} : total_wide[FIELD_W-1:0];
        end else begin : g_tot_ext
            assign total_sat = FIELD_W'(total_wide);
        end
    endgenerate

    always_comb begin
        n_bytes_left  = r_bytes_left;
        n_partial     = r_partial;
        n_char_count  = r_char_count;
        o_res_valid   = 1'b0;
        o_res         = '0;
        o_res.kind    = KIND_CHAR;
        if (i_accept) begin
            if (r_bytes_left != 3'd0) begin
                n_partial    = shifted;
                n_bytes_left = r_bytes_left - 3'd1;
                if (r_bytes_left == 3'd1) begin
                    o_res_valid          = 1'b1;
                    o_res.code_point     = shifted;
                    o_res.index_or_total = index_sat;
                    o_res.stored         = below_buf;
                    n_char_count         = count_inc;
                end
            end else if (i_data_byte == 8'h00) begin
                o_res_valid          = 1'b1;
                o_res.kind           = below_buf ? KIND_END_OK : KIND_END_TRUNC;
                o_res.index_or_total = total_sat;
                n_char_count         = '0;
            end else if (!i_data_byte[7]) begin
                o_res_valid          = 1'b1;
                o_res.code_point     = CODE_W'(i_data_byte);
                o_res.index_or_total = index_sat;
                o_res.stored         = below_buf;
                n_char_count         = count_inc;
            end else if ((i_data_byte & 8'hfe) == 8'hfc) begin
                n_bytes_left = 3'd5;
                n_partial    = CODE_W'(i_data_byte & 8'h01);
            end else if ((i_data_byte & 8'hfc) == 8'hf8) begin
                n_bytes_left = 3'd4;
                n_partial    = CODE_W'(i_data_byte & 8'h03);
            end else if ((i_data_byte & 8'hf8) == 8'hf0) begin
                n_bytes_left = 3'd3;
                n_partial    = CODE_W'(i_data_byte & 8'h07);
            end else if ((i_data_byte & 8'hf0) == 8'he0) begin
                n_bytes_left = 3'd2;
                n_partial    = CODE_W'(i_data_byte & 8'h0f);
            end else if ((i_data_byte & 8'he0) == 8'hc0) begin
                n_bytes_left = 3'd1;
                n_partial    = CODE_W'(i_data_byte & 8'h1f);
            end else begin
                o_res_valid          = 1'b1;
                o_res.kind           = KIND_BAD_LEAD;
                o_res.index_or_total = index_sat;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bytes_left <= '0;
            r_partial    <= '0;
            r_char_count <= '0;
        end else begin
            r_bytes_left <= n_bytes_left;
            r_partial    <= n_partial;
            r_char_count <= n_char_count;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/u8dec_outbuf.sv =====
// Result register plus one skid entry; stall to the input side is registered.
// Depends on u8dec_pkg.
`default_nettype none

module u8dec_outbuf
    import u8dec_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_push,
    input  wire t_result i_res,
    input  wire logic    i_stall,
    output logic         o_valid,
    output logic         o_full,
    output t_result      o_res
);

    logic    r_out_valid, n_out_valid;
    logic    r_skid_valid, n_skid_valid;
    t_result r_out, n_out;
    t_result r_skid, n_skid;
    logic    out_free;

    assign out_free = ~r_out_valid | ~i_stall;

    always_comb begin
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        n_out        = r_out;
        n_skid       = r_skid;
        if (out_free) begin
            if (r_skid_valid) begin
                n_out        = r_skid;
                n_out_valid  = 1'b1;
                n_skid_valid = 1'b0;
            end else if (i_push) begin
                n_out       = i_res;
                n_out_valid = 1'b1;
            end else begin
                n_out_valid = 1'b0;
            end
        end else if (i_push) begin
            n_skid       = i_res;
            n_skid_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_valid = r_out_valid;
    assign o_full  = r_skid_valid;
    assign o_res   = r_out;

endmodule

`default_nettype wire

// ===== rtl/core/utf8_stream_decoder.sv =====
// Top level of the UTF-8 stream decoder (1- to 6-byte forms).
// Depends on u8dec_pkg, u8dec_cfg, u8dec_core and u8dec_outbuf.
//
// One byte is taken per cycle while o_stall is low; its result (if any) goes
// to a result register plus one skid entry that part the two channels, so
// o_stall rises only when the downstream side has held off a result and a
// second one is waiting; it is a register output. Result kinds: character
// with index, end ok, end truncated (count at or above buffer_chars),
// invalid lead byte skipped. buffer_chars sits at byte address 0 of the APB
// port; the user must write it only while the block is idle (not enforced).
`default_nettype none

module utf8_stream_decoder
    import u8dec_pkg::*;
#(
    parameter int COUNT_BITS = 24
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    output logic                       o_stall,
    input  wire logic [7:0]            i_data_byte,
    output logic                       o_valid,
    input  wire logic                  i_stall,
    output logic      [1:0]            o_kind,
    output logic      [CODE_W-1:0]     o_code_point,
    output logic      [FIELD_W-1:0]    o_index_or_total,
    output logic                       o_stored,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [CFG_DATA_W-1:0] pwdata,
    output logic      [CFG_DATA_W-1:0] prdata,
    output logic                       pready
);

    logic               buf_full;
    logic               accept;
    logic               res_valid;
    logic [FIELD_W-1:0] buffer_chars;
    t_result            res;
    t_result            out_res;

    assign o_stall = buf_full;
    assign accept  = i_valid & ~buf_full;

    u8dec_cfg u_cfg (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .o_buffer_chars (buffer_chars)
    );

    u8dec_core #(
        .COUNT_BITS (COUNT_BITS)
    ) u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (accept),
        .i_data_byte    (i_data_byte),
        .i_buffer_chars (buffer_chars),
        .o_res_valid    (res_valid),
        .o_res          (res)
    );

    u8dec_outbuf u_outbuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_valid),
        .i_res   (res),
        .i_stall (i_stall),
        .o_valid (o_valid),
        .o_full  (buf_full),
        .o_res   (out_res)
    );

    assign o_kind           = out_res.kind;
    assign o_code_point     = out_res.code_point;
    assign o_index_or_total = out_res.index_or_total;
    assign o_stored         = out_res.stored;

endmodule

`default_nettype wire

// ===== rtl/core/u8dec_checker.sv =====
// Port-level checks for utf8_stream_decoder, attached by bind.
// Depends on u8dec_pkg.
`default_nettype none

module u8dec_checker
    import u8dec_pkg::*;
(
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               o_stall,
    input wire logic               o_valid,
    input wire logic               i_stall,
    input wire logic [1:0]         o_kind,
    input wire logic [CODE_W-1:0]  o_code_point,
    input wire logic [FIELD_W-1:0] o_index_or_total,
    input wire logic               o_stored
);

    // a held-off result stays put
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_kind) && $stable(o_code_point)
            && $stable(o_index_or_total) && $stable(o_stored))
        else $error("result changed while stalled");

    // input is held off only while a result is pending on the output
    a_stall_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("stall without a pending result");

    a_non_char_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind != KIND_CHAR |-> o_code_point == '0 && !o_stored)
        else $error("non-character result carries character fields");

    a_end_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_kind == KIND_END_OK || o_kind == KIND_END_TRUNC)
            |-> o_index_or_total != '0)
        else $error("end total of zero");

    // nothing pending right after reset is released
    a_idle_after_reset: assert property (@(posedge i_clk)
        $rose(i_rst_n) |-> !o_valid && !o_stall)
        else $error("result or stall present after reset");

endmodule

bind utf8_stream_decoder u8dec_checker u_u8dec_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_stall          (o_stall),
    .o_valid          (o_valid),
    .i_stall          (i_stall),
    .o_kind           (o_kind),
    .o_code_point     (o_code_point),
    .o_index_or_total (o_index_or_total),
    .o_stored         (o_stored)
);

`default_nettype wire

// ===== test/tb_utf8_stream_decoder.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for utf8_stream_decoder: byte stream in, decoded results out.
// Depends on u8dec_pkg and the decoder RTL; the predictor is kept inside this file.

module tb_utf8_stream_decoder;
    import u8dec_pkg::*;

    localparam int CLK_PERIOD = 12;
    localparam int COUNT_BITS = 24;
    localparam logic [FIELD_W-1:0] COUNT_MAX = {FIELD_W{1'b1}};
    localparam logic [CFG_ADDR_W-1:0] BUF_CHARS_ADDR = {REG_BUFFER_CHARS, 2'b00};
    localparam int MAX_REPORTS = 10;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_PERIODIC
    } t_stall_mode;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_valid = 1'b0;
    logic                  o_stall;
    logic [7:0]            i_data_byte = 8'h00;
    logic                  o_valid;
    logic                  i_stall = 1'b0;
    logic [1:0]            o_kind;
    logic [CODE_W-1:0]     o_code_point;
    logic [FIELD_W-1:0]    o_index_or_total;
    logic                  o_stored;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr = '0;
    logic [CFG_DATA_W-1:0] pwdata = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    utf8_stream_decoder #(
        .COUNT_BITS(COUNT_BITS)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_data_byte     (i_data_byte),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_kind          (o_kind),
        .o_code_point    (o_code_point),
        .o_index_or_total(o_index_or_total),
        .o_stored        (o_stored),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    // decoder mirror state
    logic [2:0]         dec_left = '0;
    logic [CODE_W-1:0]  dec_partial = '0;
    logic [FIELD_W-1:0] dec_count = '0;
    logic [FIELD_W-1:0] buf_chars = BUF_CHARS_RESET;

    logic [7:0] pending_bytes[$];
    t_result    expected_results[$];

    int bytes_queued = 0;
    int bytes_sent = 0;
    int results_checked = 0;
    int config_writes = 0;
    int errors = 0;
    int kind_seen[4] = '{0, 0, 0, 0};

    int burst_left = 0;
    int gap_left = 0;
    t_stall_mode stall_mode = STALL_NONE;
    int stall_mode_left = 0;
    int stall_tick = 0;

    initial begin
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    task automatic decode_byte(input logic [7:0] b);
        t_result r;
        logic    is_char;
        r = '0;
        is_char = 1'b0;
        if (dec_left != 0) begin
            dec_partial = {dec_partial[CODE_W-7:0], b[5:0]};
            dec_left = dec_left - 3'd1;
            if (dec_left == 0) begin
                r.code_point = dec_partial;
                is_char = 1'b1;
            end
        end else if (b == 8'h00) begin
            r.kind = (dec_count >= buf_chars) ? KIND_END_TRUNC : KIND_END_OK;
            r.index_or_total = (dec_count == COUNT_MAX) ? dec_count : dec_count + 1'b1;
            dec_count = '0;
            expected_results.push_back(r);
        end else begin
            casez (b)
                8'b0???????: begin
                    r.code_point = CODE_W'(b);
                    is_char = 1'b1;
                end
                8'b110?????: begin dec_left = 3'd1; dec_partial = CODE_W'(b[4:0]); end
                8'b1110????: begin dec_left = 3'd2; dec_partial = CODE_W'(b[3:0]); end
                8'b11110???: begin dec_left = 3'd3; dec_partial = CODE_W'(b[2:0]); end
                8'b111110??: begin dec_left = 3'd4; dec_partial = CODE_W'(b[1:0]); end
                8'b1111110?: begin dec_left = 3'd5; dec_partial = CODE_W'(b[0]); end
                default: begin
                    r.kind = KIND_BAD_LEAD;
                    r.index_or_total = dec_count;
                    expected_results.push_back(r);
                end
            endcase
        end
        if (is_char) begin
            r.kind = KIND_CHAR;
            r.index_or_total = dec_count;
            r.stored = (dec_count < buf_chars);
            if (dec_count != COUNT_MAX) dec_count = dec_count + 1'b1;
            expected_results.push_back(r);
        end
    endtask

    // sender: bursts of random length separated by random gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                decode_byte(i_data_byte);
                pending_bytes.delete(0);
                bytes_sent++;
            end
            if (i_valid && o_stall) begin
                i_valid <= 1'b1;
            end else if (gap_left > 0) begin
                gap_left--;
                i_valid <= 1'b0;
            end else if (pending_bytes.size() != 0) begin
                i_valid <= 1'b1;
                i_data_byte <= pending_bytes[0];
                if (burst_left <= 1) begin
                    burst_left = $urandom_range(1, 40);
                    gap_left = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 8);
                end else begin
                    burst_left--;
                end
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // receiver back-pressure, mode changes every so often
    always @(posedge i_clk) begin
        if (stall_mode_left == 0) begin
            stall_mode = t_stall_mode'($urandom_range(0, 3));
            stall_mode_left = $urandom_range(50, 200);
        end else begin
            stall_mode_left--;
        end
        stall_tick++;
        case (stall_mode)
            STALL_NONE:  i_stall <= 1'b0;
            STALL_LIGHT: i_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY: i_stall <= ($urandom_range(0, 9) < 7);
            default:     i_stall <= (stall_tick % 3 == 0);
        endcase
    end

    function automatic void report_result_mismatch(input string what, input t_result want,
                                                   input t_result got);
        errors++;
        if (errors <= MAX_REPORTS) begin
            $display("[%0t] %s: exp kind=%0d code=%h idx=%0d stored=%0b", $realtime, what,
                     want.kind, want.code_point, want.index_or_total, want.stored);
            $display("[%0t] %s: got kind=%0d code=%h idx=%0d stored=%0b", $realtime, what,
                     got.kind, got.code_point, got.index_or_total, got.stored);
        end
    endfunction

    always @(posedge i_clk) begin : result_monitor
        t_result got;
        t_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            got.kind = o_kind;
            got.code_point = o_code_point;
            got.index_or_total = o_index_or_total;
            got.stored = o_stored;
            if (expected_results.size() == 0) begin
                report_result_mismatch("unexpected transaction", '0, got);
            end else begin
                want = expected_results.pop_front();
                if (got.kind !== want.kind || got.code_point !== want.code_point ||
                    got.index_or_total !== want.index_or_total || got.stored !== want.stored) begin
                    report_result_mismatch("mismatch", want, got);
                end
            end
            results_checked++;
            kind_seen[o_kind]++;
        end
    end

    task automatic write_buffer_chars(input logic [FIELD_W-1:0] chars);
        @(posedge i_clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= BUF_CHARS_ADDR;
        pwdata <= CFG_DATA_W'(chars);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        buf_chars = chars;
        config_writes++;
        pwrite <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (prdata[FIELD_W-1:0] !== chars) begin
            errors++;
            if (errors <= MAX_REPORTS)
                $display("[%0t] buffer_chars readback: exp %0d got %0d", $realtime, chars,
                         prdata[FIELD_W-1:0]);
        end
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic push_byte(input logic [7:0] b);
        pending_bytes.push_back(b);
        bytes_queued++;
    endtask

    // well-formed form of len bytes; noisy randomizes some continuation prefixes
    task automatic push_char(input int len, input logic [CODE_W-1:0] code, input bit noisy);
        logic [7:0] lead;
        logic [1:0] top;
        if (len == 1)
            lead = {1'b0, code[6:0]};
        else
            lead = (8'hFF << (8 - len)) | (8'(code >> (6 * (len - 1))) & (8'hFF >> (len + 1)));
        push_byte(lead);
        for (int i = len - 2; i >= 0; i--) begin
            top = (noisy && $urandom_range(0, 3) == 0) ? 2'($urandom) : 2'b10;
            push_byte({top, 6'(code >> (6 * i))});
        end
    endtask

    task automatic push_random_strings(input int n_bytes);
        int start;
        int n_chars;
        int sel;
        int len;
        int nbits;
        logic [31:0] code;
        start = bytes_queued;
        while (bytes_queued - start < n_bytes) begin
            n_chars = $urandom_range(0, 12);
            repeat (n_chars) begin
                sel = $urandom_range(0, 99);
                len = $urandom_range(1, 6);
                nbits = (len == 1) ? 7 : 5 * len + 1;
                code = $urandom() & (32'hFFFFFFFF >> (32 - nbits));
                if ($urandom_range(0, 9) == 0) code = 32'hFFFFFFFF >> (32 - nbits);
                else if ($urandom_range(0, 9) == 0) code = '0;
                if (len == 1 && code == 0) code = 32'd1;
                if (sel < 84) begin
                    push_char(len, code[CODE_W-1:0], 1'b1);
                end else if (sel < 91) begin
                    push_byte(($urandom_range(0, 4) == 0) ? 8'($urandom_range(8'hFE, 8'hFF))
                                                           : 8'($urandom_range(8'h80, 8'hBF)));
                end else if (sel < 96) begin
                    // form cut short after its lead byte; following bytes are absorbed as continuations
                    len = $urandom_range(2, 6);
                    push_byte((8'hFF << (8 - len)) | (8'($urandom) & (8'hFF >> (len + 1))));
                    repeat ($urandom_range(0, len - 2)) push_byte({2'b10, 6'($urandom)});
                end else begin
                    push_byte(8'($urandom));
                end
            end
            if ($urandom_range(0, 9) != 0) push_byte(8'h00);
        end
    endtask

    task automatic drain();
        while (pending_bytes.size() != 0 || i_valid || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset capacity: extremes of the 1-, 2- and 6-byte forms and invalid leads
        push_char(1, 'h41, 1'b0);
        push_char(1, 'h7F, 1'b0);
        push_char(2, '1, 1'b0);
        push_char(6, '1, 1'b0);
        push_byte(8'h80);
        push_byte(8'hFE);
        push_byte(8'hFF);
        push_byte(8'h00);
        drain();

        // capacity of one: zero byte inside a form, truncation, empty string
        write_buffer_chars(24'd1);
        push_byte(8'hE0);
        push_byte(8'h00);
        push_byte(8'h80);
        push_char(5, '0, 1'b0);
        push_char(1, 'h41, 1'b0);
        push_byte(8'h00);
        push_byte(8'h00);
        drain();

        // zero capacity: nothing stored, every end truncated
        write_buffer_chars(24'd0);
        push_char(1, 'h41, 1'b0);
        push_byte(8'h00);
        push_byte(8'h00);
        drain();

        foreach (kind_seen[k]) begin
            case (k)
                0: write_buffer_chars(24'hFFFFFF);
                1: write_buffer_chars(24'd1);
                2: write_buffer_chars(24'd4);
                default: write_buffer_chars(24'(9 * k - 18));
            endcase
            push_random_strings(240);
            drain();
        end
        write_buffer_chars(24'($urandom_range(2, 12)));
        push_random_strings(240);
        drain();
        write_buffer_chars(BUF_CHARS_RESET);
        push_random_strings(240);
        drain();

        repeat (8) @(posedge i_clk);
        $display("Run covered %0d bytes, %0d results, %0d capacity settings.", bytes_sent,
                 results_checked, config_writes);
        $display("Results by kind: char %0d, end ok %0d, end truncated %0d, bad lead %0d.",
                 kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3]);
        if (errors == 0 && expected_results.size() == 0) begin
            $display("tb_utf8_stream_decoder: PASS");
        end else begin
            $display("tb_utf8_stream_decoder: FAIL");
        end
        $finish;
    end

    initial begin
        #(CLK_PERIOD * 200000);
        $display("Timeout with %0d results outstanding.", expected_results.size());
        $display("tb_utf8_stream_decoder: FAIL");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/u8dec_pkg.sv
rtl/core/u8dec_cfg.sv
rtl/core/u8dec_core.sv
rtl/core/u8dec_outbuf.sv
rtl/core/utf8_stream_decoder.sv
rtl/core/u8dec_checker.sv
test/tb_utf8_stream_decoder.sv
